FILE: hw/rtl/moving_sum_threshold_detector_macros.svh
// assertion macros for the moving sum threshold detector
// no dependencies; included by the top level
`ifndef MOVING_SUM_THRESHOLD_DETECTOR_MACROS_SVH
`define MOVING_SUM_THRESHOLD_DETECTOR_MACROS_SVH

// same-cycle implication, disabled during reset
`define MSTD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define MSTD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/mstd_pkg.sv
// widths, reset values and phase codes for the moving sum threshold detector
// no dependencies
package mstd_pkg;

    localparam int SAMPLE_W        = 12;
    localparam int ENTRY_W         = 13;
    localparam int ACC_W           = 19;
    localparam int CNT_W           = 7;
    localparam int VALUE_W         = 24;
    localparam int THRESH_W        = 23;
    localparam int SUM_W           = 26;

    localparam int WINDOW_LEN_DEF  = 1024;
    localparam int CAL_SAMPLES_DEF = 100;

    localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(15000);

    typedef enum logic [1:0] {
        PHASE_CAL     = 2'd0,
        PHASE_DETECT  = 2'd1,
        PHASE_LATCHED = 2'd2
    } phase_t;

endpackage

FILE: hw/rtl/moving_sum_threshold_detector.sv
// moving window sum threshold detector: calibration, ring memory, running value
// depends on mstd_pkg and moving_sum_threshold_detector_macros.svh
//
//  channel   direction  handshake                 payload
//  s_        in         s_valid / s_ready         s_sample
//  m_        out        m_valid / m_ready         m_phase, m_window_value, m_detected
//  cfg_      in         cfg_valid / cfg_ready     cfg_detect_threshold
//
// one sample per cycle sustained while m_ready is high. the ring is read once per
// sample at accept and, past calibration, written once; the running value is
// updated by one add, magnitude and compare in the second stage.
// no clearing pass after reset: a fill flag makes ring entries read as zero
// until the write pointer has wrapped once. both ready outputs are low in reset.
// a stalled result holds the second stage; the first stage takes one more request,
// then the input stalls.
`include "moving_sum_threshold_detector_macros.svh"

module moving_sum_threshold_detector
    import mstd_pkg::*;
#(
    parameter int WINDOW_LEN  = WINDOW_LEN_DEF,
    parameter int CAL_SAMPLES = CAL_SAMPLES_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [SAMPLE_W-1:0] s_sample,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [1:0]          m_phase,
    output logic [VALUE_W-1:0]  m_window_value,
    output logic                m_detected,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [THRESH_W-1:0] cfg_detect_threshold
);

    localparam int PTR_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW_LEN - 1);
    localparam logic [CNT_W-1:0] CAL_DONE = CNT_W'(CAL_SAMPLES);

    // exact division by CAL_SAMPLES for any ACC_W-bit sum
    localparam int CAL_SHIFT = ACC_W + $clog2(CAL_SAMPLES);
    localparam int RECIP_W   = ACC_W + 2;
    localparam logic [RECIP_W-1:0] CAL_RECIP =
        RECIP_W'(((64'd1 << CAL_SHIFT) / CAL_SAMPLES) + 1);
    localparam int PROD_W = ACC_W + RECIP_W;

    // ring memory
    logic [ENTRY_W-1:0] ring [WINDOW_LEN];
    logic [ENTRY_W-1:0] rd_data_reg;

    // first stage
    logic               s1_valid_reg;
    logic               s1_cal_reg;
    logic               s1_old_ok_reg;
    logic [ENTRY_W-1:0] s1_entry_reg;

    // state
    logic [ACC_W-1:0]    cal_acc_reg;
    logic [CNT_W-1:0]    cal_cnt_reg;
    logic [SAMPLE_W-1:0] dc_offset_reg;
    logic [PTR_W-1:0]    wr_ptr_reg;
    logic                fill_reg;
    logic [VALUE_W-1:0]  running_value_reg;
    logic                detect_latch_reg;
    logic [THRESH_W-1:0] threshold_reg;

    // result register
    logic               m_valid_reg;
    phase_t             m_phase_reg;
    logic [VALUE_W-1:0] m_value_reg;
    logic               m_detected_reg;

    logic                s_accept;
    logic                m_load;
    logic                s1_adv;
    logic                cal_active;
    logic [ACC_W-1:0]    cal_acc_next;
    logic [PROD_W-1:0]   cal_prod;
    logic [SAMPLE_W-1:0] dc_offset_next;
    logic [ENTRY_W-1:0]  entry_new;
    logic [PTR_W-1:0]    wr_ptr_next;
    logic                wr_en;
    logic                old_ok;

    logic [ENTRY_W-1:0]  old_entry;
    logic [SUM_W-1:0]    sum;
    logic [SUM_W-1:0]    mag;
    logic [VALUE_W-1:0]  running_value_next;
    logic                hit;
    phase_t              phase_next;
    logic [VALUE_W-1:0]  value_next;
    logic                detected_next;

    assign m_load   = !m_valid_reg || m_ready;
    assign s_ready  = aresetn && (!s1_valid_reg || m_load);
    assign s_accept = s_valid && s_ready;
    assign s1_adv   = s1_valid_reg && m_load;
    assign cfg_ready = aresetn;

    assign cal_active     = (cal_cnt_reg != CAL_DONE);
    assign cal_acc_next   = cal_acc_reg + ACC_W'(s_sample);
    assign cal_prod       = PROD_W'(cal_acc_next) * PROD_W'(CAL_RECIP);
    assign dc_offset_next = cal_prod[CAL_SHIFT +: SAMPLE_W];

    assign entry_new   = {1'b0, s_sample} - {1'b0, dc_offset_reg};
    assign wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
    assign wr_en       = s_accept && !cal_active;
    // the oldest entry was written only once the pointer has gone around
    assign old_ok      = fill_reg || (wr_ptr_reg == PTR_LAST);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ring[wr_ptr_reg] <= entry_new;
        end
        if (s_accept) begin
            rd_data_reg   <= ring[wr_ptr_next];
            s1_cal_reg    <= cal_active;
            s1_old_ok_reg <= old_ok;
            s1_entry_reg  <= entry_new;
        end
    end

    // second stage: running value update
    always_comb begin
        old_entry = s1_old_ok_reg ? rd_data_reg : '0;
        sum = {2'b00, running_value_reg}
            + {{(SUM_W-ENTRY_W){s1_entry_reg[ENTRY_W-1]}}, s1_entry_reg}
            - {{(SUM_W-ENTRY_W){old_entry[ENTRY_W-1]}}, old_entry};
        mag = sum[SUM_W-1] ? (~sum + 1'b1) : sum;
        running_value_next = (|mag[SUM_W-1:VALUE_W]) ? '1 : mag[VALUE_W-1:0];
        hit = (running_value_next >= {1'b0, threshold_reg});

        priority if (detect_latch_reg) begin
            phase_next    = PHASE_LATCHED;
            value_next    = running_value_reg;
            detected_next = 1'b1;
        end else if (s1_cal_reg) begin
            phase_next    = PHASE_CAL;
            value_next    = running_value_reg;
            detected_next = 1'b0;
        end else begin
            phase_next    = hit ? PHASE_LATCHED : PHASE_DETECT;
            value_next    = running_value_next;
            detected_next = hit;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg      <= 1'b0;
            cal_acc_reg       <= '0;
            cal_cnt_reg       <= '0;
            dc_offset_reg     <= '0;
            wr_ptr_reg        <= '0;
            fill_reg          <= 1'b0;
            running_value_reg <= '0;
            detect_latch_reg  <= 1'b0;
            threshold_reg     <= THRESH_RESET;
            m_valid_reg       <= 1'b0;
        end else begin
            if (cfg_valid) begin
                threshold_reg <= cfg_detect_threshold;
            end
            if (s_ready) begin
                s1_valid_reg <= s_valid;
            end
            if (s_accept) begin
                if (cal_active) begin
                    cal_acc_reg <= cal_acc_next;
                    cal_cnt_reg <= cal_cnt_reg + 1'b1;
                    if (cal_cnt_reg == CAL_DONE - 1'b1) begin
                        dc_offset_reg <= dc_offset_next;
                    end
                end else begin
                    wr_ptr_reg <= wr_ptr_next;
                    if (wr_ptr_reg == PTR_LAST) begin
                        fill_reg <= 1'b1;
                    end
                end
            end
            if (s1_adv && !detect_latch_reg && !s1_cal_reg) begin
                running_value_reg <= running_value_next;
                detect_latch_reg  <= hit;
            end
            if (m_load) begin
                m_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            m_phase_reg    <= phase_next;
            m_value_reg    <= value_next;
            m_detected_reg <= detected_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_phase        = m_phase_reg;
    assign m_window_value = m_value_reg;
    assign m_detected     = m_detected_reg;

    `MSTD_ASSERT_NEXT(a_latch_sticky, aclk, aresetn, detect_latch_reg, detect_latch_reg,
                      "detect latch cleared without reset")
    `MSTD_ASSERT_NEXT(a_value_held, aclk, aresetn, detect_latch_reg,
                      $stable(running_value_reg), "running value moved after detection")
    `MSTD_ASSERT_NOW(a_cal_zero, aclk, aresetn, cal_active,
                     (running_value_reg == '0) && !detect_latch_reg,
                     "running value active during calibration")
    `MSTD_ASSERT_NOW(a_det_phase, aclk, aresetn, m_valid_reg && m_detected_reg,
                     m_phase_reg == PHASE_LATCHED, "detected result without latched phase")

endmodule
